### hdl/uvsg_pkg.sv
// ----------------------------------------------------------------------------
// uvsg_pkg: shared types and constants of the UV sphere vertex generator
// Beat layouts, configuration register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package uvsg_pkg;

  localparam int unsigned MAX_SUBDIVISIONS = 255;

  // configuration register indexes
  localparam logic [2:0] CFG_CENTER_X      = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y      = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z      = 3'd2;
  localparam logic [2:0] CFG_SPHERE_RADIUS = 3'd3;
  localparam logic [2:0] CFG_SLICE_COUNT   = 3'd4;

  // phase divider: quotient bits, resolved three per stage
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = 6;
  localparam int unsigned DIV_QW     = DIV_STEPS * DIV_STAGES;

  // quarter-wave polynomial coefficients, Q30
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  localparam int unsigned LANES = 4;  // sin t, cos t, sin p, cos p

  typedef struct packed {
    logic [7:0] slice_index;
    logic [7:0] stack_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic signed [15:0] position_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        index_top;
    logic [15:0]        index_bottom;
    logic               quad_valid;
    logic               index_error;
  } out_t;

  typedef struct packed {
    logic [15:0] index_top;
    logic [15:0] index_bottom;
    logic        quad_valid;
    logic        index_error;
  } info_t;

  typedef struct packed {
    logic [7:0] slice_index;
    logic [7:0] stack_index;
    info_t      info;
  } front_t;

  typedef struct packed {
    logic [15:0] phase_t;
    logic [15:0] phase_p;
    info_t       info;
  } phase_t;

  typedef struct packed {
    logic signed [15:0] sin_t;
    logic signed [15:0] cos_t;
    logic signed [15:0] sin_p;
    logic signed [15:0] cos_p;
    info_t              info;
  } trig_t;

endpackage

### hdl/uvsg_divider.sv
// ----------------------------------------------------------------------------
// uvsg_divider: pipelined phase divider
// Restoring division of both angle numerators by 2n, three bits per stage.
// ----------------------------------------------------------------------------
module uvsg_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        n_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uvsg_pkg::front_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uvsg_pkg::phase_t  out_data_o
);

  localparam int unsigned STG = uvsg_pkg::DIV_STAGES;
  localparam int unsigned QW  = uvsg_pkg::DIV_QW;

  logic [8:0]        divisor;
  logic [QW+7:0]     dvd      [2];
  logic [8:0]        rem_c    [STG][2];
  logic [QW-1:0]     work_c   [STG][2];
  logic [8:0]        rem_q    [STG][2];
  logic [QW-1:0]     work_q   [STG][2];
  uvsg_pkg::info_t   info_q   [STG];
  logic [STG-1:0]    v_q;
  logic [STG-1:0]    rdy;

  assign divisor = {n_i, 1'b0};
  // theta numerator sl*65536+n, phi numerator st*131072+n
  assign dvd[0] = {2'b00, in_data_i.slice_index, 16'h0000} + (QW+8)'(n_i);
  assign dvd[1] = {1'b0, in_data_i.stack_index, 17'h00000} + (QW+8)'(n_i);

  always_comb begin
    logic [9:0] t;
    t = '0;
    for (int k = 0; k < STG; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          rem_c[k][l]  = {1'b0, dvd[l][QW+7:QW]};
          work_c[k][l] = dvd[l][QW-1:0];
        end else begin
          rem_c[k][l]  = rem_q[k-1][l];
          work_c[k][l] = work_q[k-1][l];
        end
        for (int s = 0; s < uvsg_pkg::DIV_STEPS; s++) begin
          t = {rem_c[k][l], work_c[k][l][QW-1]};
          if (t >= {1'b0, divisor}) begin
            rem_c[k][l]  = 9'(t - {1'b0, divisor});
            work_c[k][l] = {work_c[k][l][QW-2:0], 1'b1};
          end else begin
            rem_c[k][l]  = t[8:0];
            work_c[k][l] = {work_c[k][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    rdy[STG-1] = !v_q[STG-1] || out_ready_i;
    for (int k = STG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < STG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STG; k++) begin
      if (rdy[k]) begin
        rem_q[k]  <= rem_c[k];
        work_q[k] <= work_c[k];
        info_q[k] <= (k == 0) ? in_data_i.info : info_q[k-1];
      end
    end
  end

  assign in_ready_o           = rdy[0];
  assign out_valid_o          = v_q[STG-1];
  assign out_data_o.phase_t   = work_q[STG-1][0][15:0];
  assign out_data_o.phase_p   = work_q[STG-1][1][15:0];
  assign out_data_o.info      = info_q[STG-1];

endmodule

### hdl/uvsg_sine.sv
// ----------------------------------------------------------------------------
// uvsg_sine: four-lane quarter-wave sine pipeline
// Folds each phase into a quarter, evaluates the odd polynomial, restores sign.
// ----------------------------------------------------------------------------
module uvsg_sine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uvsg_pkg::phase_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uvsg_pkg::trig_t   out_data_o
);

  localparam int unsigned STG = 6;
  localparam int unsigned L   = uvsg_pkg::LANES;

  logic [15:0]        ph      [L];
  logic [14:0]        xa_c    [L];
  logic [14:0]        x2_c    [L];
  logic [29:0]        i1_c    [L];
  logic [30:0]        i2_c    [L];
  logic [15:0]        s_c     [L];

  logic [14:0]        xa_q    [L];
  logic [L-1:0]       na_q;
  logic [14:0]        xb_q    [L];
  logic [14:0]        x2b_q   [L];
  logic [L-1:0]       nb_q;
  logic [14:0]        xc_q    [L];
  logic [14:0]        x2c_q   [L];
  logic [29:0]        i1_q    [L];
  logic [L-1:0]       nc_q;
  logic [14:0]        xd_q    [L];
  logic [30:0]        i2_q    [L];
  logic [L-1:0]       nd_q;
  logic [15:0]        s_q     [L];
  logic [L-1:0]       ne_q;
  logic signed [15:0] sn_q    [L];

  uvsg_pkg::info_t    info_q  [STG];
  logic [STG-1:0]     v_q;
  logic [STG-1:0]     rdy;

  assign ph[0] = in_data_i.phase_t;
  assign ph[1] = in_data_i.phase_t + 16'h4000;
  assign ph[2] = in_data_i.phase_p;
  assign ph[3] = in_data_i.phase_p + 16'h4000;

  always_comb begin
    logic [29:0] pb;
    logic [41:0] pc;
    logic [44:0] pd;
    logic [45:0] pe;
    pb = '0; pc = '0; pd = '0; pe = '0;
    for (int l = 0; l < L; l++) begin
      // odd quadrants run the quarter backwards
      xa_c[l] = ph[l][14] ? 15'(15'd16384 - {1'b0, ph[l][13:0]}) : {1'b0, ph[l][13:0]};
      pb      = 30'(xa_q[l]) * 30'(xa_q[l]);
      x2_c[l] = 15'((pb + 30'd8192) >> 14);
      pc      = 42'(uvsg_pkg::SIN_C) * 42'(x2b_q[l]);
      i1_c[l] = uvsg_pkg::SIN_B - 30'((pc + 42'd8192) >> 14);
      pd      = 45'(i1_q[l]) * 45'(x2c_q[l]);
      i2_c[l] = uvsg_pkg::SIN_A - 31'((pd + 45'd8192) >> 14);
      pe      = 46'(i2_q[l]) * 46'(xd_q[l]);
      s_c[l]  = 16'((pe + 46'h2000_0000) >> 30);
    end
  end

  always_comb begin
    rdy[STG-1] = !v_q[STG-1] || out_ready_i;
    for (int k = STG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < STG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STG; k++) begin
      if (rdy[k]) begin
        info_q[k] <= (k == 0) ? in_data_i.info : info_q[k-1];
      end
    end
    for (int l = 0; l < L; l++) begin
      if (rdy[0]) begin
        xa_q[l] <= xa_c[l];
        na_q[l] <= ph[l][15];
      end
      if (rdy[1]) begin
        xb_q[l]  <= xa_q[l];
        x2b_q[l] <= x2_c[l];
        nb_q[l]  <= na_q[l];
      end
      if (rdy[2]) begin
        xc_q[l]  <= xb_q[l];
        x2c_q[l] <= x2b_q[l];
        i1_q[l]  <= i1_c[l];
        nc_q[l]  <= nb_q[l];
      end
      if (rdy[3]) begin
        xd_q[l] <= xc_q[l];
        i2_q[l] <= i2_c[l];
        nd_q[l] <= nc_q[l];
      end
      if (rdy[4]) begin
        s_q[l]  <= s_c[l];
        ne_q[l] <= nd_q[l];
      end
      if (rdy[5]) begin
        sn_q[l] <= ne_q[l] ? -$signed(s_q[l]) : $signed(s_q[l]);
      end
    end
  end

  assign in_ready_o       = rdy[0];
  assign out_valid_o      = v_q[STG-1];
  assign out_data_o.sin_t = sn_q[0];
  assign out_data_o.cos_t = sn_q[1];
  assign out_data_o.sin_p = sn_q[2];
  assign out_data_o.cos_p = sn_q[3];
  assign out_data_o.info  = info_q[STG-1];

endmodule

### hdl/uvsg_output.sv
// ----------------------------------------------------------------------------
// uvsg_output: normal and position stages
// Normal products, radius scaling, centre offset and saturation.
// ----------------------------------------------------------------------------
module uvsg_output (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] center_z_i,
  input  logic [15:0]        radius_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uvsg_pkg::trig_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uvsg_pkg::out_t     out_data_o
);

  localparam int unsigned STG = 4;

  // round Q14 product to nearest, halves away from zero
  function automatic logic signed [18:0] rnd14(input logic signed [32:0] p);
    logic signed [32:0] s;
    s = p + (p[32] ? 33'sd8191 : 33'sd8192);
    return 19'(s >>> 14);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  logic signed [31:0] px_c, pz_c;
  logic signed [32:0] qx_c, qy_c, qz_c;
  logic signed [16:0] rad_s;
  logic signed [19:0] vx, vy, vz;

  logic signed [31:0] px_q, pz_q;
  logic signed [15:0] ny1_q;
  logic signed [15:0] nx2_q, ny2_q, nz2_q;
  logic signed [32:0] qx_q, qy_q, qz_q;
  logic signed [15:0] nx3_q, ny3_q, nz3_q;
  uvsg_pkg::out_t     out_q;
  uvsg_pkg::info_t    info_q [STG];
  logic [STG-1:0]     v_q;
  logic [STG-1:0]     rdy;

  assign px_c  = in_data_i.sin_t * in_data_i.cos_p;
  assign pz_c  = in_data_i.sin_t * in_data_i.sin_p;
  assign rad_s = $signed({1'b0, radius_i});
  assign qx_c  = nx2_q * rad_s;
  assign qy_c  = ny2_q * rad_s;
  assign qz_c  = nz2_q * rad_s;
  assign vx    = 20'(rnd14(qx_q)) + 20'(center_x_i);
  assign vy    = 20'(rnd14(qy_q)) + 20'(center_y_i);
  assign vz    = 20'(rnd14(qz_q)) + 20'(center_z_i);

  always_comb begin
    rdy[STG-1] = !v_q[STG-1] || out_ready_i;
    for (int k = STG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < STG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STG - 1; k++) begin
      if (rdy[k]) begin
        info_q[k] <= (k == 0) ? in_data_i.info : info_q[k-1];
      end
    end
    if (rdy[0]) begin
      px_q  <= px_c;
      pz_q  <= pz_c;
      ny1_q <= in_data_i.cos_t;
    end
    if (rdy[1]) begin
      nx2_q <= 16'(rnd14(33'(px_q)));
      nz2_q <= 16'(rnd14(33'(pz_q)));
      ny2_q <= ny1_q;
    end
    if (rdy[2]) begin
      qx_q  <= qx_c;
      qy_q  <= qy_c;
      qz_q  <= qz_c;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      nz3_q <= nz2_q;
    end
    if (rdy[3]) begin
      info_q[STG-1] <= info_q[STG-2];
      if (info_q[STG-2].index_error) begin
        out_q <= '{index_error: 1'b1, default: '0};
      end else begin
        out_q.position_x   <= sat16(vx);
        out_q.position_y   <= sat16(vy);
        out_q.position_z   <= sat16(vz);
        out_q.normal_x     <= nx3_q;
        out_q.normal_y     <= ny3_q;
        out_q.normal_z     <= nz3_q;
        out_q.index_top    <= info_q[STG-2].index_top;
        out_q.index_bottom <= info_q[STG-2].index_bottom;
        out_q.quad_valid   <= info_q[STG-2].quad_valid;
        out_q.index_error  <= 1'b0;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[STG-1] && (info_q[STG-1].index_error == out_q.index_error);
  assign out_data_o  = out_q;

endmodule

### hdl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator: UV sphere grid point to vertex
// Unit normal, position and mesh indices for one latitude/longitude point.
// ----------------------------------------------------------------------------
// Fully pipelined: one grid point beat can enter every cycle while the output
// is not stalled, and each result beat passes 1 index stage, 6 phase
// divider stages, 6 sine stages and 4 normal/position stages, in that order.
// Every stage carries its own valid bit and a stage
// holds only when the one after it is full and held, so bubbles are squeezed
// out and the input keeps flowing while a result waits. The angles come from
// two restoring dividers by 2n that resolve three quotient bits per stage;
// the four sines (sin/cos of both angles) run as parallel lanes of a
// quarter-wave polynomial, at most one multiply per stage. Configuration
// is written through a plain write port and must only change while the pipe
// is empty. A slice_count of zero behaves as one. A point with either index
// above n gives an all-zero beat with index_error set.
module uv_sphere_vertex_generator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  uvsg_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output uvsg_pkg::out_t out_data_o
);

  // configuration registers
  logic signed [15:0] center_x_q, center_y_q, center_z_q;
  logic [15:0]        radius_q;
  logic [7:0]         slice_count_q;
  logic [7:0]         n_eff;
  logic [8:0]         n1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      center_z_q    <= '0;
      radius_q      <= 16'd256;
      slice_count_q <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        uvsg_pkg::CFG_CENTER_X:      center_x_q    <= cfg_wdata_i;
        uvsg_pkg::CFG_CENTER_Y:      center_y_q    <= cfg_wdata_i;
        uvsg_pkg::CFG_CENTER_Z:      center_z_q    <= cfg_wdata_i;
        uvsg_pkg::CFG_SPHERE_RADIUS: radius_q      <= cfg_wdata_i;
        uvsg_pkg::CFG_SLICE_COUNT:   slice_count_q <= cfg_wdata_i[7:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // zero subdivisions act as one, clamp at the top of the range
  always_comb begin
    if (slice_count_q == 8'd0) begin
      n_eff = 8'd1;
    end else if (32'(slice_count_q) > uvsg_pkg::MAX_SUBDIVISIONS) begin
      n_eff = 8'(uvsg_pkg::MAX_SUBDIVISIONS);
    end else begin
      n_eff = slice_count_q;
    end
  end
  assign n1 = {1'b0, n_eff} + 9'd1;

  // index stage: mesh indices, quad and range flags
  uvsg_pkg::front_t front_d, front_q;
  logic             front_v_q;
  logic             front_rdy;
  logic             div_ready;

  always_comb begin
    front_d.slice_index       = in_data_i.slice_index;
    front_d.stack_index       = in_data_i.stack_index;
    front_d.info.index_top    = 16'(16'(in_data_i.slice_index) * 16'(n1))
                              + 16'(in_data_i.stack_index);
    front_d.info.index_bottom = front_d.info.index_top + 16'(n1);
    front_d.info.quad_valid   = (in_data_i.slice_index != n_eff)
                             && (in_data_i.stack_index != n_eff);
    front_d.info.index_error  = (in_data_i.slice_index > n_eff)
                             || (in_data_i.stack_index > n_eff);
  end

  assign front_rdy  = !front_v_q || div_ready;
  assign in_stall_o = !front_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else if (front_rdy) begin
      front_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_rdy) begin
      front_q <= front_d;
    end
  end

  // phase dividers
  uvsg_pkg::phase_t ph_data;
  logic             ph_valid, ph_ready;

  uvsg_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .in_valid_i  (front_v_q),
    .in_ready_o  (div_ready),
    .in_data_i   (front_q),
    .out_valid_o (ph_valid),
    .out_ready_i (ph_ready),
    .out_data_o  (ph_data)
  );

  // sine and cosine lanes
  uvsg_pkg::trig_t trig_data;
  logic            trig_valid, trig_ready;

  uvsg_sine u_sine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ph_valid),
    .in_ready_o  (ph_ready),
    .in_data_i   (ph_data),
    .out_valid_o (trig_valid),
    .out_ready_i (trig_ready),
    .out_data_o  (trig_data)
  );

  // normal, scaling and centre offset; last stage is the output register
  uvsg_output u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .center_z_i  (center_z_q),
    .radius_i    (radius_q),
    .in_valid_i  (trig_valid),
    .in_ready_o  (trig_ready),
    .in_data_i   (trig_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

  // an out-of-range beat carries nothing but the error flag
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.index_error |->
      !out_data_o.quad_valid && out_data_o.normal_y == 16'sd0
      && out_data_o.position_y == 16'sd0 && out_data_o.index_top == 16'd0)
    else $error("error beat carries non-zero fields");

  // the lower row index is always one row on from the upper one
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.index_error |->
      out_data_o.index_bottom == out_data_o.index_top + 16'(n1))
    else $error("index_bottom is not one row below index_top");

  // input is only held back when the index stage holds a beat
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> front_v_q)
    else $error("input stalled with an empty index stage");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the UV sphere vertex generator
// Drives grid point beats under varied configurations and back-pressure,
// predicts every vertex beat in integer arithmetic and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PIPE_DEPTH  = 17;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [2:0]     cfg_index_i;
  logic [15:0]    cfg_wdata_i;
  logic           in_valid_i;
  logic           in_stall_o;
  uvsg_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  uvsg_pkg::out_t out_data_o;

  uv_sphere_vertex_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // shadow copy of the configuration registers
  logic [15:0] cen_x, cen_y, cen_z, radius;
  logic [7:0]  subdiv;

  uvsg_pkg::out_t vertex_q[$];
  int unsigned errors;
  int unsigned vertices_seen;
  int unsigned points_sent;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;   // receiver hold-off, counted down each cycle

  // ---- predictor -----------------------------------------------------------
  // quarter-wave sine polynomial, Q14 in, Q14 out
  function automatic longint quarter_wave(longint x);
    longint x2, i1, i2;
    x2 = (x * x + 8192) >>> 14;
    i1 = longint'(uvsg_pkg::SIN_B) - ((longint'(uvsg_pkg::SIN_C) * x2 + 8192) >>> 14);
    i2 = longint'(uvsg_pkg::SIN_A) - ((i1 * x2 + 8192) >>> 14);
    return (i2 * x + (longint'(1) << 29)) >>> 30;
  endfunction

  // sine of a 16-bit phase, one turn = 65536
  function automatic longint sine_of(int unsigned phase);
    int unsigned p, q;
    longint r, x, s;
    p = phase & 32'hFFFF;
    q = p >> 14;
    r = p & 32'h3FFF;
    x = q[0] ? 16384 - r : r;
    s = quarter_wave(x);
    return q[1] ? -s : s;
  endfunction

  // product scaled down, halves away from zero
  function automatic longint scale_round(longint a, longint b, int sh);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (p < 0) ? -m : m;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic uvsg_pkg::out_t vertex_of(uvsg_pkg::in_t pt);
    uvsg_pkg::out_t v;
    int unsigned n, sl, st, ph_t, ph_p, top;
    longint sin_t, cos_t, sin_p, cos_p, nx, ny, nz, rad;
    n  = (subdiv == 8'd0) ? 1 : 32'(subdiv);
    sl = 32'(pt.slice_index);
    st = 32'(pt.stack_index);
    v  = '0;
    if (sl > n || st > n) begin
      v.index_error = 1'b1;
      return v;
    end
    ph_t  = (sl * 65536 + n) / (2 * n);
    ph_p  = ((st * 131072 + n) / (2 * n)) & 32'hFFFF;
    sin_t = sine_of(ph_t);
    cos_t = sine_of(ph_t + 16384);
    sin_p = sine_of(ph_p);
    cos_p = sine_of(ph_p + 16384);
    nx    = scale_round(sin_t, cos_p, 14);
    ny    = cos_t;
    nz    = scale_round(sin_t, sin_p, 14);
    rad   = longint'(radius);
    top   = sl * (n + 1) + st;
    v.position_x   = clamp16(scale_round(nx, rad, 14) + longint'($signed(cen_x)));
    v.position_y   = clamp16(scale_round(ny, rad, 14) + longint'($signed(cen_y)));
    v.position_z   = clamp16(scale_round(nz, rad, 14) + longint'($signed(cen_z)));
    v.normal_x     = nx[15:0];
    v.normal_y     = ny[15:0];
    v.normal_z     = nz[15:0];
    v.index_top    = top[15:0];
    v.index_bottom = 16'(top + n + 1);
    v.quad_valid   = (sl != n) && (st != n);
    return v;
  endfunction

  // ---- receiver and checker ------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $error("vertex beat with nothing expected");
          errors++;
        end else begin
          uvsg_pkg::out_t e;
          e = vertex_q.pop_front();
          vertices_seen++;
          if (out_data_o.position_x !== e.position_x) begin
            $error("position_x exp %0d got %0d", e.position_x, out_data_o.position_x);
            errors++;
          end
          if (out_data_o.position_y !== e.position_y) begin
            $error("position_y exp %0d got %0d", e.position_y, out_data_o.position_y);
            errors++;
          end
          if (out_data_o.position_z !== e.position_z) begin
            $error("position_z exp %0d got %0d", e.position_z, out_data_o.position_z);
            errors++;
          end
          if (out_data_o.normal_x !== e.normal_x) begin
            $error("normal_x exp %0d got %0d", e.normal_x, out_data_o.normal_x);
            errors++;
          end
          if (out_data_o.normal_y !== e.normal_y) begin
            $error("normal_y exp %0d got %0d", e.normal_y, out_data_o.normal_y);
            errors++;
          end
          if (out_data_o.normal_z !== e.normal_z) begin
            $error("normal_z exp %0d got %0d", e.normal_z, out_data_o.normal_z);
            errors++;
          end
          if (out_data_o.index_top !== e.index_top) begin
            $error("index_top exp %0d got %0d", e.index_top, out_data_o.index_top);
            errors++;
          end
          if (out_data_o.index_bottom !== e.index_bottom) begin
            $error("index_bottom exp %0d got %0d", e.index_bottom,
                   out_data_o.index_bottom);
            errors++;
          end
          if (out_data_o.quad_valid !== e.quad_valid) begin
            $error("quad_valid exp %0b got %0b", e.quad_valid, out_data_o.quad_valid);
            errors++;
          end
          if (out_data_o.index_error !== e.index_error) begin
            $error("index_error exp %0b got %0b", e.index_error, out_data_o.index_error);
            errors++;
          end
        end
      end
      // long hold-off takes priority over the random stall
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---- sender --------------------------------------------------------------
  // one grid point beat; valid stays high across back-to-back beats
  task automatic send_point(input logic [7:0] sl, input logic [7:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{slice_index: sl, stack_index: st};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    vertex_q.push_back(vertex_of('{slice_index: sl, stack_index: st}));
    points_sent++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // register write with pipe drained; shadow updated in step
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      uvsg_pkg::CFG_CENTER_X:      cen_x  = val;
      uvsg_pkg::CFG_CENTER_Y:      cen_y  = val;
      uvsg_pkg::CFG_CENTER_Z:      cen_z  = val;
      uvsg_pkg::CFG_SPHERE_RADIUS: radius = val;
      uvsg_pkg::CFG_SLICE_COUNT:   subdiv = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] cz, input logic [15:0] r,
                            input logic [7:0] n);
    go_idle();
    write_reg(uvsg_pkg::CFG_CENTER_X, cx);
    write_reg(uvsg_pkg::CFG_CENTER_Y, cy);
    write_reg(uvsg_pkg::CFG_CENTER_Z, cz);
    write_reg(uvsg_pkg::CFG_SPHERE_RADIUS, r);
    write_reg(uvsg_pkg::CFG_SLICE_COUNT, {8'h00, n});
    cfg_we_i <= 1'b0;
  endtask

  // ---- tests ---------------------------------------------------------------
  // corners, poles, last row/column, out-of-range and wrapped indices
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_point(0, 0);
    send_point(5, 0);
    send_point(10, 10);
    send_point(9, 9);
    send_point(10, 3);
    send_point(3, 10);
    send_point(11, 0);
    send_point(0, 11);
    send_point(8'hFF, 8'hFF);
    set_sphere(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 8'd255);
    send_point(255, 255);
    send_point(254, 254);
    send_point(128, 64);
    send_point(0, 128);
    send_point(255, 0);
    // zero subdivisions behave as one
    set_sphere(16'h8000, 16'h7FFF, 16'h1234, 16'h0000, 8'd0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(1, 0);
    send_point(2, 0);
    set_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0100, 8'd4);
    send_point(1, 1);
    send_point(2, 3);
    send_point(4, 4);
    send_point(5, 2);
  endtask

  // mostly in-range points with random content, a few out of range
  task automatic test_random(input int unsigned count);
    int unsigned n;
    logic [7:0] sl, st;
    n = (subdiv == 8'd0) ? 1 : 32'(subdiv);
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        sl = 8'($urandom);
        st = 8'($urandom);
      end else begin
        sl = 8'($urandom_range(n));
        st = 8'($urandom_range(n));
      end
      send_point(sl, st);
    end
  endtask

  task automatic random_sphere();
    logic [7:0] n;
    n = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
    set_sphere(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), n);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 60;
    test_random(80);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = uvsg_pkg::CFG_CENTER_X;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    errors        = 0;
    vertices_seen = 0;
    points_sent   = 0;
    cycles        = 0;
    hold_cycles   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cen_x  = 16'h0000;
    cen_y  = 16'h0000;
    cen_z  = 16'h0000;
    radius = 16'h0100;
    subdiv = 8'd10;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    // three idling regimes, four random spheres each
    for (int phase = 0; phase < 3; phase++) begin
      for (int k = 0; k < 4; k++) begin
        random_sphere();
        send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 66 : 0;
        recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 33 : 0;
        test_random(90);
      end
    end
    random_sphere();
    test_backpressure();
    // sender pauses until everything is back
    go_idle();
    test_random(20);
    go_idle();

    $display("Checked %0d vertex beats from %0d grid points over several spheres,",
             vertices_seen, points_sent);
    $display("with edge rows, bad indices, saturation and heavy back-pressure.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
